// ----- hw/rtl/dda_pkg.sv -----
// Shared constants and codes of the DDA line pixel generator.
package dda_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int OFS_W        = 27;
	localparam int COLOR_W      = 32;
	localparam int ROW_BYTES_W  = 15;
	localparam int PIXEL_BITS_W = 6;
	localparam int CFG_W        = 15;
	localparam int CFG_IDX_W    = 1;

	localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RST  = 15'd4096;
	localparam logic [PIXEL_BITS_W-1:0] PIXEL_BITS_RST = 6'd32;

	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;
	localparam int         BITS_PER_BYTE = 8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS = 1'b1;

endpackage

// ----- hw/rtl/dda_line_solver.sv -----
// Line setup: step count by iterative square root and step sizes by long division.
module dda_line_solver
	import dda_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int CNT_W     = COORD_BITS + 1,
	localparam int STEP_W    = FRAC_BITS + 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [CNT_W-1:0]  dx,
	input  logic signed [CNT_W-1:0]  dy,
	output logic                     done,
	output logic [CNT_W-1:0]         cnt,
	output logic signed [STEP_W-1:0] step_x,
	output logic signed [STEP_W-1:0] step_y
);

	localparam int RAD_W = 2 * COORD_BITS + 2;
	localparam int NUM_W = COORD_BITS + FRAC_BITS + 2;
	localparam int SUB_W = COORD_BITS + 4;
	localparam int IT_W  = $clog2(NUM_W + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ_X,
		S_SQ_Y,
		S_ROOT,
		S_SETUP_X,
		S_DIV_X,
		S_SETUP_Y,
		S_DIV_Y,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic signed [CNT_W-1:0]   dx_q;
	logic signed [CNT_W-1:0]   dy_q;
	logic [RAD_W-1:0]          rad_q;
	logic [SUB_W-1:0]          rem_q;
	logic [CNT_W-1:0]          root_q;
	logic [NUM_W-1:0]          num_q;
	logic [STEP_W-1:0]         quo_q;
	logic [IT_W-1:0]           it_q;
	logic signed [STEP_W-1:0]  step_x_q;

	logic signed [CNT_W-1:0]   mul_op;
	logic signed [2*CNT_W-1:0] prod;
	logic [SUB_W-1:0]          sqrt_shift;
	logic [SUB_W-1:0]          sqrt_trial;
	logic [SUB_W-1:0]          div_shift;
	logic [SUB_W-1:0]          div_dvsr;
	logic [SUB_W-1:0]          sub_a;
	logic [SUB_W-1:0]          sub_b;
	logic [SUB_W:0]            diff;
	logic                      fits;
	logic [CNT_W-1:0]          root_nxt;
	logic [CNT_W-1:0]          abs_x;
	logic [CNT_W-1:0]          abs_y;
	logic [NUM_W-1:0]          num_init_x;
	logic [NUM_W-1:0]          num_init_y;
	logic [STEP_W-1:0]         quo_signed_x;
	logic [STEP_W-1:0]         quo_signed_y;
	logic                      root_last;
	logic                      div_last;

	// One multiplier forms both squares in turn.
	assign mul_op = (state_q == S_SQ_Y) ? dy_q : dx_q;
	assign prod   = mul_op * mul_op;

	// One subtractor serves the root digits and the quotient bits.
	assign sqrt_shift = {rem_q[SUB_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign sqrt_trial = SUB_W'({root_q, 2'b01});
	assign div_shift  = {rem_q[SUB_W-2:0], num_q[NUM_W-1]};
	assign div_dvsr   = SUB_W'({root_q, 1'b0});
	assign sub_a      = (state_q == S_ROOT) ? sqrt_shift : div_shift;
	assign sub_b      = (state_q == S_ROOT) ? sqrt_trial : div_dvsr;
	assign diff       = {1'b0, sub_a} - {1'b0, sub_b};
	assign fits       = !diff[SUB_W];
	assign root_nxt   = {root_q[CNT_W-2:0], fits};

	assign abs_x      = dx_q[CNT_W-1] ? (~dx_q + 1'b1) : dx_q;
	assign abs_y      = dy_q[CNT_W-1] ? (~dy_q + 1'b1) : dy_q;
	assign num_init_x = (NUM_W'(abs_x) << (FRAC_BITS + 1)) + NUM_W'(root_q);
	assign num_init_y = (NUM_W'(abs_y) << (FRAC_BITS + 1)) + NUM_W'(root_q);

	assign quo_signed_x = dx_q[CNT_W-1] ? (~quo_q + 1'b1) : quo_q;
	assign quo_signed_y = dy_q[CNT_W-1] ? (~quo_q + 1'b1) : quo_q;

	assign root_last = (it_q == IT_W'(CNT_W - 1));
	assign div_last  = (it_q == IT_W'(NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dx_q     <= '0;
			dy_q     <= '0;
			rad_q    <= '0;
			rem_q    <= '0;
			root_q   <= '0;
			num_q    <= '0;
			quo_q    <= '0;
			it_q     <= '0;
			step_x_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						dx_q    <= dx;
						dy_q    <= dy;
						state_q <= S_SQ_X;
					end
				end
				S_SQ_X: begin
					rad_q   <= $unsigned(prod);
					state_q <= S_SQ_Y;
				end
				S_SQ_Y: begin
					rad_q   <= rad_q + $unsigned(prod);
					rem_q   <= '0;
					root_q  <= '0;
					it_q    <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rad_q  <= rad_q << 2;
					rem_q  <= fits ? diff[SUB_W-1:0] : sqrt_shift;
					root_q <= root_nxt;
					it_q   <= it_q + 1'b1;
					if (root_last) begin
						if (root_nxt == '0) begin
							step_x_q <= '0;
							quo_q    <= '0;
							state_q  <= S_FINISH;
						end else begin
							state_q <= S_SETUP_X;
						end
					end
				end
				S_SETUP_X: begin
					num_q   <= num_init_x;
					rem_q   <= '0;
					quo_q   <= '0;
					it_q    <= '0;
					state_q <= S_DIV_X;
				end
				S_DIV_X: begin
					num_q <= num_q << 1;
					rem_q <= fits ? diff[SUB_W-1:0] : div_shift;
					quo_q <= {quo_q[STEP_W-2:0], fits};
					it_q  <= it_q + 1'b1;
					if (div_last) begin
						state_q <= S_SETUP_Y;
					end
				end
				S_SETUP_Y: begin
					step_x_q <= quo_signed_x;
					num_q    <= num_init_y;
					rem_q    <= '0;
					quo_q    <= '0;
					it_q     <= '0;
					state_q  <= S_DIV_Y;
				end
				S_DIV_Y: begin
					num_q <= num_q << 1;
					rem_q <= fits ? diff[SUB_W-1:0] : div_shift;
					quo_q <= {quo_q[STEP_W-2:0], fits};
					it_q  <= it_q + 1'b1;
					if (div_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == S_FINISH);
	assign cnt    = root_q;
	assign step_x = step_x_q;
	assign step_y = quo_signed_y;

endmodule

// ----- hw/rtl/dda_line_pixel_generator.sv -----
// Top level of the DDA line pixel generator: command intake, accumulators and pixel output.
//
//  Channel      Direction  Transfer carries
//  s_axis_*     in         one command: load a line or emit the next pixel
//  m_axis_*     out        one pixel: coordinates, byte offset, color, write enable
//  cfg_*        in         one register write, row_bytes or pixel_bits
//
//  A step command passes accept, rounding of the accumulators and offset multiply into the
//  output register before the next command is taken; the last waits while a stalled pixel
//  holds the output register. A step with no pixels left is taken without effect.
//  A load holds off the next command until the solver is done; its shared subtractor runs
//  COORD_BITS+1 root iterations and two divisions of COORD_BITS+FRAC_BITS+2 iterations
//  each; a zero-length line skips the divisions.
//  Reset restores the register defaults and clears the line state at once.
//  A pixel waiting in the output register does not block the next command transfer.
module dda_line_pixel_generator
	import dda_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int IN_DW     = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8,
	localparam int OUT_DW    = ((2 * COORD_BITS + OFS_W + COLOR_W + 1 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Fields from bit 0: start_x, start_y, end_x, end_y, color.
	input  logic [IN_DW-1:0]     s_axis_tdata,
	// Fields from bit 0: command.
	input  logic [0:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Fields from bit 0: pixel_x, pixel_y, byte_offset, color_out, write_enable.
	output logic [OUT_DW-1:0]    m_axis_tdata,
	output logic                 m_axis_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CNT_W  = COORD_BITS + 1;
	localparam int STEP_W = FRAC_BITS + 2;
	localparam int ACC_W  = COORD_BITS + 1 + FRAC_BITS;
	localparam int OXW    = (COORD_BITS + 17 > OFS_W) ? COORD_BITS + 17 : OFS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD_WAIT,
		ST_PIX_ROUND,
		ST_PIX_OUT
	} state_t;

	function automatic logic [COORD_BITS-1:0] round_coord(input logic [ACC_W-1:0] a);
		logic [ACC_W:0] ext;
		logic [ACC_W:0] mag;
		logic [ACC_W:0] rnd;
		ext = {a[ACC_W-1], a};
		mag = a[ACC_W-1] ? (~ext + 1'b1) : ext;
		rnd = (mag + ((ACC_W + 1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return a[ACC_W-1] ? (~rnd[COORD_BITS-1:0] + 1'b1) : rnd[COORD_BITS-1:0];
	endfunction

	state_t                       state_q;
	logic [ROW_BYTES_W-1:0]       row_bytes_q;
	logic [PIXEL_BITS_W-1:0]      pixel_bits_q;
	logic [ACC_W-1:0]             acc_x_q;
	logic [ACC_W-1:0]             acc_y_q;
	logic signed [STEP_W-1:0]     step_x_q;
	logic signed [STEP_W-1:0]     step_y_q;
	logic [CNT_W-1:0]             remaining_q;
	logic [COLOR_W-1:0]           line_color_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [OUT_DW-1:0]            out_data_q;
	logic                         out_last_q;

	logic signed [COORD_BITS-1:0]   in_start_x;
	logic signed [COORD_BITS-1:0]   in_start_y;
	logic signed [COORD_BITS-1:0]   in_end_x;
	logic signed [COORD_BITS-1:0]   in_end_y;
	logic [COLOR_W-1:0]             in_color;
	logic signed [CNT_W-1:0]        in_dx;
	logic signed [CNT_W-1:0]        in_dy;
	logic                           in_xfer;
	logic                           slv_start;
	logic                           slv_done;
	logic [CNT_W-1:0]               slv_cnt;
	logic signed [STEP_W-1:0]       slv_step_x;
	logic signed [STEP_W-1:0]       slv_step_y;
	logic [2:0]                     stride;
	logic signed [COORD_BITS+15:0]  prod_y;
	logic signed [COORD_BITS+3:0]   prod_x;
	logic signed [OXW-1:0]          ofs_wide;
	logic                           write_en;
	logic                           out_load;

	assign in_start_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
	assign in_start_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
	assign in_end_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
	assign in_end_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
	assign in_color   = s_axis_tdata[4*COORD_BITS +: COLOR_W];
	assign in_dx      = CNT_W'(in_end_x) - CNT_W'(in_start_x);
	assign in_dy      = CNT_W'(in_end_y) - CNT_W'(in_start_y);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign slv_start     = in_xfer && (s_axis_tuser[0] == CMD_LOAD);

	dda_line_solver #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_solver (
		.clk   (clk),
		.arst_n(arst_n),
		.start (slv_start),
		.dx    (in_dx),
		.dy    (in_dy),
		.done  (slv_done),
		.cnt   (slv_cnt),
		.step_x(slv_step_x),
		.step_y(slv_step_y)
	);

	assign stride   = 3'(pixel_bits_q / BITS_PER_BYTE);
	assign prod_y   = py_q * $signed({1'b0, row_bytes_q});
	assign prod_x   = px_q * $signed({1'b0, stride});
	assign ofs_wide = OXW'(prod_y) + OXW'(prod_x);
	assign write_en = (line_color_q[COLOR_W-1 -: 8] != ALPHA_OPAQUE);
	assign out_load = (state_q == ST_PIX_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_bytes_q  <= ROW_BYTES_RST;
			pixel_bits_q <= PIXEL_BITS_RST;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			remaining_q  <= '0;
			line_color_q <= '0;
			px_q         <= '0;
			py_q         <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_BYTES:  row_bytes_q  <= cfg_data[ROW_BYTES_W-1:0];
					REG_PIXEL_BITS: pixel_bits_q <= cfg_data[PIXEL_BITS_W-1:0];
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser[0] == CMD_LOAD) begin
							acc_x_q      <= {in_start_x[COORD_BITS-1], in_start_x,
								{FRAC_BITS{1'b0}}};
							acc_y_q      <= {in_start_y[COORD_BITS-1], in_start_y,
								{FRAC_BITS{1'b0}}};
							line_color_q <= in_color;
							state_q      <= ST_LOAD_WAIT;
						end else if (remaining_q != '0) begin
							state_q <= ST_PIX_ROUND;
						end
					end
				end
				ST_LOAD_WAIT: begin
					if (slv_done) begin
						remaining_q <= slv_cnt;
						step_x_q    <= slv_step_x;
						step_y_q    <= slv_step_y;
						state_q     <= ST_IDLE;
					end
				end
				ST_PIX_ROUND: begin
					px_q        <= round_coord(acc_x_q);
					py_q        <= round_coord(acc_y_q);
					last_q      <= (remaining_q == CNT_W'(1));
					acc_x_q     <= acc_x_q + ACC_W'(step_x_q);
					acc_y_q     <= acc_y_q + ACC_W'(step_y_q);
					remaining_q <= remaining_q - 1'b1;
					state_q     <= ST_PIX_OUT;
				end
				ST_PIX_OUT: begin
					if (out_load) begin
						out_data_q <= OUT_DW'({write_en, line_color_q,
							ofs_wide[OFS_W-1:0], py_q, px_q});
						out_last_q <= last_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- hw/rtl/dda_line_checker.sv -----
// Port-level assertions for the DDA line pixel generator and their binding.
module dda_line_checker
	import dda_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int OUT_DW    = ((2 * COORD_BITS + OFS_W + COLOR_W + 1 + 7) / 8) * 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [0:0]           s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [OUT_DW-1:0]    m_axis_tdata,
	input logic                 m_axis_tlast
);

	localparam int COLOR_LSB = 2 * COORD_BITS + OFS_W;
	localparam int WE_BIT    = COLOR_LSB + COLOR_W;

	// A stalled pixel keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	else $error("pixel changed while stalled");

	// A load transfer starts the line setup, which blocks the next command.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_LOAD) |=> !s_axis_tready)
	else $error("command taken during line setup");

	// A new pixel appears only after the pixel stages held the input side off.
	a_pixel_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
	else $error("pixel appeared without pixel stages");

	// The write enable follows the alpha byte of the delivered color.
	a_write_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[WE_BIT] == (m_axis_tdata[WE_BIT-1 -: 8] != ALPHA_OPAQUE)))
	else $error("write enable does not match alpha");

endmodule

bind dda_line_pixel_generator dda_line_checker #(
	.COORD_BITS(COORD_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_checker (.*);
